>>> design/rs_syndrome_calculator_macros.svh
// assertion macros for the reed-solomon syndrome calculator
`ifndef RS_SYNDROME_CALCULATOR_MACROS_SVH
`define RS_SYNDROME_CALCULATOR_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define RSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define RSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rsc_pkg.sv
// shared constants, types and gf(32) arithmetic for the syndrome calculator
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int SYM_W              = 5;
  localparam int GF_ORDER           = 31;
  localparam int CORRECTABLE_ERRORS = 1;
  localparam int NUM_SYN            = 2 * CORRECTABLE_ERRORS;
  localparam int CNT_W              = $clog2(NUM_SYN + 1);
  localparam int POS_W              = 5;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(GF_ORDER - 1);
  localparam logic [SYM_W-1:0] GF_ONE   = SYM_W'(1);
  // x^5 = x^2 + 1
  localparam logic [SYM_W-1:0] GF_POLY_LOW = 5'b00101;

  // alpha^e in polynomial form
  localparam logic [SYM_W-1:0] GF_EXP [GF_ORDER] = '{
    5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd5,  5'd10, 5'd20,
    5'd13, 5'd26, 5'd17, 5'd7,  5'd14, 5'd28, 5'd29, 5'd31,
    5'd27, 5'd19, 5'd3,  5'd6,  5'd12, 5'd24, 5'd21, 5'd15,
    5'd30, 5'd25, 5'd23, 5'd11, 5'd22, 5'd9,  5'd18
  };

  // control that every cell sees in the same cycle
  typedef struct packed {
    logic step;   // symbol transfer this cycle
    logic wrap;   // that symbol closes the codeword
    logic shift;  // result transfer, hold chain moves one place
  } rsc_ctrl_t;

  function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                              input logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] r;
    r = '0;
    for (int k = SYM_W - 1; k >= 0; k--) begin
      r = {r[SYM_W-2:0], 1'b0} ^ (r[SYM_W-1] ? GF_POLY_LOW : '0);
      if (b[k]) begin
        r = r ^ a;
      end
    end
    return r;
  endfunction

endpackage

>>> design/rs_syndrome_calculator.sv
// top level of the reed-solomon syndrome calculator over gf(32)
`timescale 1ns / 1ps

// Reed-Solomon syndrome calculator over GF(32), field polynomial x^5+x^2+1.
// A codeword is 31 five-bit symbols, symbol j being the coefficient of x^j,
// sent first to last. One symbol is taken per cycle, back to back: a row of
// 2T identical cells each keeps one syndrome S_i and the power alpha^(i*j)
// of the current position, and all cells fold the symbol in within the same
// cycle. On the 31st symbol the finished syndromes drop into a hold chain
// that shifts towards the output, one transfer per cycle, S_1 first and S_2T
// flagged as last. Input stalls only when the output side holds results
// back so long that the closing symbol of the next codeword arrives while
// syndromes of the previous one still wait; the closing symbol is then held
// until the chain has emptied. S_1 is offered in the cycle after the
// closing symbol is taken.

module rs_syndrome_calculator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rsc_pkg::SYM_W-1:0] symbol_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rsc_pkg::SYM_W-1:0] syndrome_number_o,
  output logic [rsc_pkg::SYM_W-1:0] syndrome_value_o,
  output logic                      last_syndrome_o
);
  import rsc_pkg::*;

  `include "rs_syndrome_calculator_macros.svh"

  // position of the next symbol within the codeword
  logic [POS_W-1:0] pos_q, pos_d;
  // results still waiting in the hold chain
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic      in_xfer, out_xfer, at_last;
  rsc_ctrl_t ctrl;

  // hold chain links, the far end shifts in zeros
  logic [SYM_W-1:0] hold [NUM_SYN+1];

  assign at_last  = (pos_q == LAST_POS);
  // closing symbol waits for an empty hold chain
  assign in_ready_o = !at_last || (cnt_q == '0);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_xfer    = out_valid_o && out_ready_i;

  assign ctrl.step  = in_xfer;
  assign ctrl.wrap  = at_last;
  assign ctrl.shift = out_xfer;

  always_comb begin
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (in_xfer) begin
      pos_d = at_last ? '0 : pos_q + POS_W'(1);
    end
    // a load only ever happens into an empty chain, so no overlap with a shift
    if (in_xfer && at_last) begin
      cnt_d = CNT_W'(NUM_SYN);
    end else if (out_xfer) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  assign hold[NUM_SYN] = '0;

  // cell k holds S_(k+1) and steps its power by alpha^(k+1) per symbol
  for (genvar k = 0; k < NUM_SYN; k++) begin : g_cell
    localparam logic [SYM_W-1:0] CellMult = GF_EXP[(k + 1) % GF_ORDER];
    rsc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .symbol_i (symbol_i),
      .mult_i   (CellMult),
      .hold_i   (hold[k+1]),
      .hold_o   (hold[k])
    );
  end

  assign syndrome_value_o  = hold[0];
  assign syndrome_number_o = SYM_W'(NUM_SYN + 1 - int'(cnt_q));
  assign last_syndrome_o   = (cnt_q == CNT_W'(1));

  // closing symbol never taken while results of the last codeword wait
  `RSC_ASSERT_SAME(a_wrap_empty, in_xfer && at_last, cnt_q == '0, "wrap with full hold chain")
  // codeword end restarts the position and fills the chain
  `RSC_ASSERT_NEXT(a_wrap_load, in_xfer && at_last,
                   (pos_q == '0) && (cnt_q == CNT_W'(NUM_SYN)), "bad state after codeword end")
  // the flagged last result empties the chain
  `RSC_ASSERT_NEXT(a_last_drain, out_xfer && last_syndrome_o, cnt_q == '0,
                   "hold chain not empty after last result")
  // position stays within the codeword
  `RSC_ASSERT_SAME(a_pos_range, 1'b1, pos_q <= LAST_POS, "position out of range")

endmodule

>>> design/rsc_cell.sv
// one syndrome cell: accumulator, running power of alpha and a hold stage
`timescale 1ns / 1ps

module rsc_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rsc_pkg::rsc_ctrl_t       ctrl_i,
  input  logic [rsc_pkg::SYM_W-1:0] symbol_i,
  input  logic [rsc_pkg::SYM_W-1:0] mult_i,
  input  logic [rsc_pkg::SYM_W-1:0] hold_i,
  output logic [rsc_pkg::SYM_W-1:0] hold_o
);
  import rsc_pkg::*;

  logic [SYM_W-1:0] acc_q, acc_d;
  logic [SYM_W-1:0] power_q, power_d;
  logic [SYM_W-1:0] hold_q, hold_d;
  logic [SYM_W-1:0] acc_sum;

  assign acc_sum = acc_q ^ gf_mul(symbol_i, power_q);

  always_comb begin
    acc_d   = acc_q;
    power_d = power_q;
    hold_d  = hold_q;
    if (ctrl_i.step) begin
      if (ctrl_i.wrap) begin
        acc_d   = '0;
        power_d = GF_ONE;
        hold_d  = acc_sum;
      end else begin
        acc_d   = acc_sum;
        power_d = gf_mul(power_q, mult_i);
      end
    end
    if (ctrl_i.shift) begin
      hold_d = hold_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      power_q <= GF_ONE;
    end else begin
      acc_q   <= acc_d;
      power_q <= power_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  assign hold_o = hold_q;

endmodule
